/* rtl/mvbfb_pkg.sv */
// Package: shared types and constants of the vertical-byte framebuffer.
`timescale 1ns / 1ps
package mvbfb_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int IDX_W        = 20;
  localparam int COORD_W      = 10;
  localparam int SIZE_W       = 11;
  localparam int STRIDE_W     = 11;
  localparam int OFFSET_W     = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 11;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_GET  = 2'd1;
  localparam logic [1:0] OP_FILL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_OFFSET = 1'b1;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd128;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd0;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [SIZE_W-1:0]  rect_w;
    logic [SIZE_W-1:0]  rect_h;
    logic               color;
  } cmd_t;

  typedef struct packed {
    logic pixel;
    logic out_of_range;
  } res_t;

  typedef enum logic [1:0] {
    KIND_SET  = 2'd0,
    KIND_GET  = 2'd1,
    KIND_FILL = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [SIZE_W-1:0]  rect_w;
    logic [SIZE_W-1:0]  rect_h;
    logic               color;
  } job_t;

  typedef struct packed {
    logic [STRIDE_W-1:0] row_stride;
    logic [OFFSET_W-1:0] byte_offset;
  } cfg_t;

endpackage

/* rtl/mvbfb_ram.sv */
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module mvbfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mvbfb_front.sv */
// Front end: accept commands, classify them and hold them in a two-entry queue.
`timescale 1ns / 1ps
module mvbfb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          hold_i,
  input  logic          push,
  output logic          full,
  input  mvbfb_pkg::cmd_t cmd_i,
  output logic          job_valid_o,
  output mvbfb_pkg::job_t job_o,
  input  logic          job_pop_i
);
  import mvbfb_pkg::*;

  job_t       job_mem_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept;
  logic       take;
  job_t       job_new;

  // Classify: empty fills and the spare op code need no memory access.
  always_comb begin
    job_new.pos_x  = cmd_i.pos_x;
    job_new.pos_y  = cmd_i.pos_y;
    job_new.rect_w = cmd_i.rect_w;
    job_new.rect_h = cmd_i.rect_h;
    job_new.color  = cmd_i.color;
    unique case (cmd_i.op)
      OP_SET:  job_new.kind = KIND_SET;
      OP_GET:  job_new.kind = KIND_GET;
      OP_FILL: begin
        if (cmd_i.rect_w == '0 || cmd_i.rect_h == '0) begin
          job_new.kind = KIND_NOP;
        end else begin
          job_new.kind = KIND_FILL;
        end
      end
      default: job_new.kind = KIND_NOP;
    endcase
  end

  assign full        = (cnt_q == 2'd2) || hold_i;
  assign accept      = push && !full;
  assign job_valid_o = (cnt_q != 2'd0);
  assign take        = job_pop_i && job_valid_o;
  assign job_o       = job_mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (accept) begin
      wp_d = ~wp_q;
    end
    if (take) begin
      rp_d = ~rp_q;
    end
    if (accept && !take) begin
      cnt_d = cnt_q + 2'd1;
    end else if (take && !accept) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_mem_q[wp_q] <= job_new;
    end
  end

endmodule

/* rtl/mvbfb_back.sv */
// Back end: clear the store, run pixel and fill jobs, queue the results.
`timescale 1ns / 1ps
module mvbfb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mvbfb_pkg::cfg_t cfg_i,
  input  logic            job_valid_i,
  input  mvbfb_pkg::job_t job_i,
  output logic            job_pop_o,
  output logic            clearing_o,
  output logic            empty,
  input  logic            pop,
  output mvbfb_pkg::res_t res_o
);
  import mvbfb_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_ADDR  = 5'b00100,
    S_READ  = 5'b01000,
    S_WRITE = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  job_t                cur_q, cur_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [SIZE_W-1:0]   col_q, col_d;
  logic [SIZE_W-1:0]   row_q, row_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [2:0]          bit_q, bit_d;
  logic                err_q, err_d;

  // One bit wider than a size: the edge plus the walk reaches past 2047.
  logic [SIZE_W:0]     px, py;
  logic                in_range;
  logic                col_last, row_last;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [7:0]          ram_wdata, ram_rdata;

  res_t                res_mem_q [2];
  logic                res_wp_q, res_rp_q;
  logic [1:0]          res_cnt_q;
  logic                res_room, res_push, res_take;
  res_t                res_new;

  assign px       = (SIZE_W+1)'(cur_q.pos_x) + (SIZE_W+1)'(col_q);
  assign py       = (SIZE_W+1)'(cur_q.pos_y) + (SIZE_W+1)'(row_q);
  assign in_range = idx_q < IDX_W'(BUFFER_BYTES);
  assign col_last = (col_q + SIZE_W'(1)) == cur_q.rect_w;
  assign row_last = (row_q + SIZE_W'(1)) == cur_q.rect_h;
  assign res_room = (res_cnt_q != 2'd2);
  assign clearing_o = (state_q == S_CLEAR);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    clr_d     = clr_q;
    col_d     = col_q;
    row_d     = row_q;
    idx_d     = idx_q;
    bit_d     = bit_q;
    err_d     = err_q;
    job_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q[ADDR_W-1:0];
    ram_wdata = (ram_rdata & ~(8'h01 << bit_q)) | (8'(cur_q.color) << bit_q);
    res_push  = 1'b0;
    res_new   = '0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(BUFFER_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (job_valid_i && res_room) begin
          job_pop_o = 1'b1;
          cur_d     = job_i;
          col_d     = '0;
          row_d     = '0;
          err_d     = 1'b0;
          if (job_i.kind == KIND_NOP) begin
            res_push = 1'b1;
          end else begin
            state_d = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        // Byte index: page times stride, plus column and offset.
        idx_d = IDX_W'(py[SIZE_W:3]) * IDX_W'(cfg_i.row_stride)
              + IDX_W'(px) + IDX_W'(cfg_i.byte_offset);
        bit_d   = py[2:0];
        state_d = S_READ;
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (cur_q.kind == KIND_GET) begin
          res_push             = 1'b1;
          res_new.pixel        = in_range & ram_rdata[bit_q];
          res_new.out_of_range = !in_range;
          state_d              = S_IDLE;
        end else begin
          ram_we = in_range;
          err_d  = err_q | !in_range;
          if (cur_q.kind == KIND_FILL && !(col_last && row_last)) begin
            state_d = S_ADDR;
            if (col_last) begin
              col_d = '0;
              row_d = row_q + SIZE_W'(1);
            end else begin
              col_d = col_q + SIZE_W'(1);
            end
          end else begin
            res_push             = 1'b1;
            res_new.out_of_range = err_q | !in_range;
            state_d              = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      col_q   <= col_d;
      row_q   <= row_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    bit_q <= bit_d;
  end

  mvbfb_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Result queue: two entries so a waiting result does not stall the next job.
  assign empty    = (res_cnt_q == 2'd0);
  assign res_take = pop && !empty;
  assign res_o    = res_mem_q[res_rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wp_q  <= 1'b0;
      res_rp_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        res_wp_q <= ~res_wp_q;
      end
      if (res_take) begin
        res_rp_q <= ~res_rp_q;
      end
      if (res_push && !res_take) begin
        res_cnt_q <= res_cnt_q + 2'd1;
      end else if (res_take && !res_push) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wp_q] <= res_new;
    end
  end

endmodule

/* rtl/mono_vertical_byte_framebuffer_top.sv */
// Top level: mono vertical-byte framebuffer with command and result queues.
`timescale 1ns / 1ps
// A set runs the address multiply, RAM read and RAM write steps on the
// single frame RAM, a get the same steps without the write; an empty fill
// or spare op code is answered from idle. A fill repeats the steps per
// pixel visited; a new job is taken only once the last is done. After
// reset all BUFFER_BYTES (1024) bytes of the frame RAM are swept to zero;
// full stays high meanwhile. Stride resets to 128, offset 0, queues empty.
module mono_vertical_byte_framebuffer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command side
  input  logic                       push,
  output logic                       full,
  input  mvbfb_pkg::cmd_t            cmd_i,
  // result side
  output logic                       empty,
  input  logic                       pop,
  output mvbfb_pkg::res_t            res_o,
  // register writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [mvbfb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mvbfb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mvbfb_pkg::*;

  cfg_t cfg_q;
  logic clearing;
  logic job_valid;
  logic job_pop;
  job_t job;

  // Register writes never stall, so always take them.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_stride  <= STRIDE_RESET;
      cfg_q.byte_offset <= OFFSET_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROW_STRIDE:  cfg_q.row_stride  <= cfg_data_i;
        REG_BYTE_OFFSET: cfg_q.byte_offset <= cfg_data_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: hold off new commands while the clearing sweep runs.
  mvbfb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (clearing),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  // Back: read-modify-write engine and result queue.
  mvbfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .clearing_o  (clearing),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_o)
  );

endmodule
